[hdl/mce_pkg.sv]
// ----------------------------------------------------------------------------
// mce_pkg
// Shared types, constants and the letter code table of the Morse encoder.
// ----------------------------------------------------------------------------
package mce_pkg;

    localparam int UNIT_W  = 24;
    localparam int DUR_W   = 26;
    localparam int CHAR_W  = 8;
    localparam int UNITS_W = 3;
    localparam int STEP_W  = 4;
    localparam int ELEMS_W = 8;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 24'd20000;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    typedef logic [STEP_W-1:0] step_t;

    // microprogram addresses
    localparam step_t STEP_DISPATCH   = 4'd0;
    localparam step_t STEP_ELEM_MARK  = 4'd1;
    localparam step_t STEP_ELEM_SPACE = 4'd2;
    localparam step_t STEP_LETTER_GAP = 4'd3;
    localparam step_t STEP_SPACE_GAP  = 4'd4;
    localparam step_t STEP_EOM_CHECK  = 4'd5;
    localparam step_t STEP_EOM_GAP    = 4'd6;
    localparam step_t STEP_MARKER     = 4'd7;
    localparam step_t STEP_TAIL_GAP   = 4'd8;

    typedef enum logic [2:0] {
        BR_SEQ,
        BR_JUMP,
        BR_MORE_ELEM,
        BR_CLASS,
        BR_EOM,
        BR_END
    } branch_t;

    typedef struct packed {
        logic                emit;
        logic                mark_lamp;
        logic                marker_lamp;
        logic                use_elem;
        logic [UNITS_W-1:0]  units;
        logic                last;
        logic                last_no_eom;
        logic                adv_elem;
        branch_t             br;
        step_t               target;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{
        emit: 1'b0, mark_lamp: 1'b0, marker_lamp: 1'b0, use_elem: 1'b0,
        units: '0, last: 1'b0, last_no_eom: 1'b0, adv_elem: 1'b0,
        br: BR_END, target: STEP_DISPATCH
    };

    // sequencer to datapath
    typedef struct packed {
        logic   load;
        logic   fire;
        ucode_t cw;
    } seq_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic is_letter;
        logic is_space;
        logic eom;
        logic more_elem;
        logic slot_free;
    } dp_status_t;

    // element lengths in units, first element in the lowest two bits, 0 ends
    function automatic logic [ELEMS_W-1:0] letter_code(input logic [4:0] idx);
        logic [ELEMS_W-1:0] c;
        unique case (idx)
            5'd0:    c = {2'd0, 2'd0, 2'd3, 2'd1};
            5'd1:    c = {2'd1, 2'd1, 2'd1, 2'd3};
            5'd2:    c = {2'd1, 2'd3, 2'd1, 2'd3};
            5'd3:    c = {2'd0, 2'd1, 2'd1, 2'd3};
            5'd4:    c = {2'd0, 2'd0, 2'd0, 2'd1};
            5'd5:    c = {2'd1, 2'd3, 2'd1, 2'd1};
            5'd6:    c = {2'd0, 2'd1, 2'd3, 2'd3};
            5'd7:    c = {2'd1, 2'd1, 2'd1, 2'd1};
            5'd8:    c = {2'd0, 2'd0, 2'd1, 2'd1};
            5'd9:    c = {2'd3, 2'd3, 2'd3, 2'd1};
            5'd10:   c = {2'd0, 2'd3, 2'd1, 2'd3};
            5'd11:   c = {2'd1, 2'd1, 2'd3, 2'd1};
            5'd12:   c = {2'd0, 2'd0, 2'd3, 2'd3};
            5'd13:   c = {2'd0, 2'd0, 2'd1, 2'd3};
            5'd14:   c = {2'd0, 2'd3, 2'd3, 2'd3};
            5'd15:   c = {2'd1, 2'd3, 2'd3, 2'd1};
            5'd16:   c = {2'd3, 2'd1, 2'd3, 2'd3};
            5'd17:   c = {2'd0, 2'd1, 2'd3, 2'd1};
            5'd18:   c = {2'd0, 2'd1, 2'd1, 2'd1};
            5'd19:   c = {2'd0, 2'd0, 2'd0, 2'd3};
            5'd20:   c = {2'd0, 2'd3, 2'd1, 2'd1};
            5'd21:   c = {2'd3, 2'd1, 2'd1, 2'd1};
            5'd22:   c = {2'd0, 2'd3, 2'd3, 2'd1};
            5'd23:   c = {2'd3, 2'd1, 2'd1, 2'd3};
            5'd24:   c = {2'd3, 2'd3, 2'd1, 2'd3};
            5'd25:   c = {2'd1, 2'd1, 2'd3, 2'd3};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[hdl/mce_ucode_rom.sv]
// ----------------------------------------------------------------------------
// mce_ucode_rom
// Control store: one control word for each step of the encoder program.
// ----------------------------------------------------------------------------
module mce_ucode_rom (
    input  mce_pkg::step_t  step,
    output mce_pkg::ucode_t cw
);
    import mce_pkg::*;

    always_comb begin
        cw = UCODE_NOP;
        unique case (step)
            STEP_DISPATCH: begin
                cw.br = BR_CLASS;
            end
            STEP_ELEM_MARK: begin
                cw.emit      = 1'b1;
                cw.mark_lamp = 1'b1;
                cw.use_elem  = 1'b1;
                cw.br        = BR_SEQ;
            end
            STEP_ELEM_SPACE: begin
                cw.emit     = 1'b1;
                cw.units    = 3'd1;
                cw.adv_elem = 1'b1;
                cw.br       = BR_MORE_ELEM;
                cw.target   = STEP_ELEM_MARK;
            end
            STEP_LETTER_GAP: begin
                cw.emit        = 1'b1;
                cw.units       = 3'd2;
                cw.last_no_eom = 1'b1;
                cw.br          = BR_JUMP;
                cw.target      = STEP_EOM_CHECK;
            end
            STEP_SPACE_GAP: begin
                cw.emit        = 1'b1;
                cw.units       = 3'd4;
                cw.last_no_eom = 1'b1;
                cw.br          = BR_SEQ;
            end
            STEP_EOM_CHECK: begin
                cw.br = BR_EOM;
            end
            STEP_EOM_GAP: begin
                cw.emit  = 1'b1;
                cw.units = 3'd4;
                cw.br    = BR_SEQ;
            end
            STEP_MARKER: begin
                cw.emit        = 1'b1;
                cw.marker_lamp = 1'b1;
                cw.units       = 3'd1;
                cw.br          = BR_SEQ;
            end
            STEP_TAIL_GAP: begin
                cw.emit  = 1'b1;
                cw.units = 3'd2;
                cw.last  = 1'b1;
                cw.br    = BR_END;
            end
            default: begin
                cw = UCODE_NOP;
            end
        endcase
    end

endmodule

[hdl/mce_sequencer.sv]
// ----------------------------------------------------------------------------
// mce_sequencer
// Step counter and branch logic that walks the encoder program per character.
// ----------------------------------------------------------------------------
module mce_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mce_pkg::dp_status_t status,
    output mce_pkg::seq_ctrl_t  ctrl
);
    import mce_pkg::*;

    logic   busy_reg, busy_next;
    step_t  step_reg, step_next;
    ucode_t cw;
    logic   load;
    logic   fire;

    mce_ucode_rom u_rom (
        .step (step_reg),
        .cw   (cw)
    );

    assign in_ready = !busy_reg;
    assign load     = in_valid && !busy_reg;
    // a step that emits waits for the output slot
    assign fire     = busy_reg && (!cw.emit || status.slot_free);

    always_comb begin
        ctrl.load = load;
        ctrl.fire = fire;
        ctrl.cw   = cw;
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (load) begin
            busy_next = 1'b1;
            step_next = STEP_DISPATCH;
        end else if (fire) begin
            unique case (cw.br)
                BR_SEQ: begin
                    step_next = step_reg + step_t'(1);
                end
                BR_JUMP: begin
                    step_next = cw.target;
                end
                BR_MORE_ELEM: begin
                    step_next = status.more_elem ? cw.target : step_reg + step_t'(1);
                end
                BR_CLASS: begin
                    if (status.is_letter) begin
                        step_next = STEP_ELEM_MARK;
                    end else if (status.is_space) begin
                        step_next = STEP_SPACE_GAP;
                    end else begin
                        step_next = STEP_EOM_CHECK;
                    end
                end
                BR_EOM: begin
                    if (status.eom) begin
                        step_next = step_reg + step_t'(1);
                    end else begin
                        busy_next = 1'b0;
                        step_next = STEP_DISPATCH;
                    end
                end
                BR_END: begin
                    busy_next = 1'b0;
                    step_next = STEP_DISPATCH;
                end
                default: begin
                    busy_next = 1'b0;
                    step_next = STEP_DISPATCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_DISPATCH;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    a_load_starts_at_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && step_reg == STEP_DISPATCH)
        else $error("character did not start at the dispatch step");

    a_step_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= STEP_TAIL_GAP)
        else $error("step counter ran past the program");

    a_dispatch_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && step_reg == STEP_DISPATCH) |=> (step_reg != STEP_DISPATCH || !busy_reg))
        else $error("dispatch step did not advance");

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cw.emit) |-> status.slot_free)
        else $error("segment emitted over a pending transaction");

endmodule

[hdl/mce_datapath.sv]
// ----------------------------------------------------------------------------
// mce_datapath
// Character latch, element shifter, duration multiply and output register.
// ----------------------------------------------------------------------------
module mce_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mce_pkg::UNIT_W-1:0]    cfg_wr_data,
    input  logic [mce_pkg::CHAR_W-1:0]    char_code,
    input  logic                          end_of_message,
    input  mce_pkg::seq_ctrl_t            ctrl,
    output mce_pkg::dp_status_t           status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          mark_lamp,
    output logic                          marker_lamp,
    output logic [mce_pkg::DUR_W-1:0]     duration_ticks,
    output logic                          last_segment
);
    import mce_pkg::*;

    logic [UNIT_W-1:0]  unit_ticks_reg;
    logic               is_letter_reg, is_space_reg, eom_reg;
    logic [ELEMS_W-1:0] elems_reg, elems_next;
    logic               out_valid_reg;
    logic               mark_reg, marker_reg, last_reg;
    logic [DUR_W-1:0]   dur_reg;

    logic [CHAR_W-1:0]  lower;
    logic               in_letter, in_space;
    logic [CHAR_W-1:0]  letter_off;
    logic [UNITS_W-1:0] units;
    logic [UNIT_W+UNITS_W-1:0] product;
    logic               emit_now;

    // fold upper case to lower
    always_comb begin
        if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z) begin
            lower = char_code + CASE_OFFSET;
        end else begin
            lower = char_code;
        end
    end

    assign in_letter  = lower >= CHAR_LOWER_A && lower <= CHAR_LOWER_Z;
    assign in_space   = lower == CHAR_SPACE;
    assign letter_off = lower - CHAR_LOWER_A;

    always_comb begin
        elems_next = elems_reg;
        if (ctrl.load) begin
            elems_next = in_letter ? letter_code(letter_off[4:0]) : '0;
        end else if (ctrl.fire && ctrl.cw.adv_elem) begin
            elems_next = {2'b00, elems_reg[ELEMS_W-1:2]};
        end
    end

    assign units    = ctrl.cw.use_elem ? {1'b0, elems_reg[1:0]} : ctrl.cw.units;
    assign product  = units * unit_ticks_reg;
    assign emit_now = ctrl.fire && ctrl.cw.emit;

    always_comb begin
        status.is_letter = is_letter_reg;
        status.is_space  = is_space_reg;
        status.eom       = eom_reg;
        status.more_elem = elems_reg[3:2] != 2'b00;
        status.slot_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unit_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            is_letter_reg <= in_letter;
            is_space_reg  <= in_space;
            eom_reg       <= end_of_message;
        end
        elems_reg <= elems_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_now) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_now) begin
            mark_reg   <= ctrl.cw.mark_lamp;
            marker_reg <= ctrl.cw.marker_lamp;
            dur_reg    <= product[DUR_W-1:0];
            last_reg   <= ctrl.cw.last || (ctrl.cw.last_no_eom && !eom_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign mark_lamp      = mark_reg;
    assign marker_lamp    = marker_reg;
    assign duration_ticks = dur_reg;
    assign last_segment   = last_reg;

endmodule

[hdl/morse_character_encoder.sv]
// ----------------------------------------------------------------------------
// morse_character_encoder
// Turns characters into timed lamp segments for Morse signaling.
// ----------------------------------------------------------------------------
// One character enters per s_ transaction (tdata = ASCII code, tlast = end of
// message). Letters of either case become dot/dash mark segments, each
// followed by a one-unit space and closed by a two-unit letter gap; a space
// gives a four-unit gap; other characters give nothing. End of message adds
// a four-unit gap, a one-unit marker flash and a two-unit gap.
// Each m_ transaction is one segment; tlast marks the last one of a character.
// cfg_wr_en/cfg_wr_data set the ticks per unit; the user must write them only
// while idle, which the block does not enforce. After the accepting cycle a
// character passes the dispatch step, then the steps of the control program:
// two per element, one for the letter or space gap, one for the end-of-message
// check and three for the tail at end of message. s_tready is low until the
// program ends. A stalled m_tready holds the output register and freezes the
// step counter at the next step that emits.
// Reset empties the output and sets the unit to 20000 ticks.
// ----------------------------------------------------------------------------
module morse_character_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] mark_lamp, [1] marker_lamp, [27:2] duration_ticks
    output logic        m_tlast    // last_segment
);
    import mce_pkg::*;

    seq_ctrl_t        ctrl;
    dp_status_t       status;
    logic             mark_lamp, marker_lamp;
    logic [DUR_W-1:0] duration_ticks;

    mce_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    mce_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .char_code      (s_tdata),
        .end_of_message (s_tlast),
        .ctrl           (ctrl),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .mark_lamp      (mark_lamp),
        .marker_lamp    (marker_lamp),
        .duration_ticks (duration_ticks),
        .last_segment   (m_tlast)
    );

    assign m_tdata = {4'b0000, duration_ticks, marker_lamp, mark_lamp};

endmodule
